// ----- hdl/aztec_calendar_date_convert_unit_assert.svh -----
// ------------------------------------------------------------------------
// aztec calendar date converter assertion macros
// clocked concurrent checks, quiet while reset is asserted
// ------------------------------------------------------------------------
`ifndef AZTEC_CALENDAR_DATE_CONVERT_UNIT_ASSERT_SVH
`define AZTEC_CALENDAR_DATE_CONVERT_UNIT_ASSERT_SVH

// explicit clock and active-low reset
`define ACDC_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// block clock and reset
`define ACDC_ASSERT(lbl, prop, msg) `ACDC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/acdc_pkg.sv -----
// ------------------------------------------------------------------------
// acdc_pkg
// constants and types of the aztec calendar date converter
// ------------------------------------------------------------------------
package acdc_pkg;

  // length of the calendar round, a multiple of every cycle used below
  localparam int unsigned ROUND_DAYS = 18980;
  localparam logic [14:0] ROUND_C    = 15'(ROUND_DAYS);

  localparam logic [19:0] CORR_RESET     = 20'd584283;
  localparam logic [14:0] CORR_RESET_RES = 15'(584283 % ROUND_DAYS);

  localparam logic [14:0] TZOLKIN_BIAS = 15'd159;
  localparam logic [14:0] YEAR_BIAS    = 15'd347;
  localparam logic [14:0] FIRE_OFS     = 15'd18;
  localparam logic [8:0]  TZOLKIN_LEN  = 9'd260;
  localparam logic [8:0]  YEAR_LEN     = 9'd365;
  localparam logic [8:0]  REG_DAYS     = 9'd360;
  localparam logic [8:0]  MONTH_LEN    = 9'd20;
  localparam logic [8:0]  TRECENA_LEN  = 9'd13;

  // day residue folding: three 14-bit chunks of the day number
  localparam int unsigned CHUNK_W = 14;
  localparam logic [14:0] K1_C = 15'((1 << CHUNK_W) % ROUND_DAYS);
  localparam logic [14:0] K2_C = 15'((1 << (2 * CHUNK_W)) % ROUND_DAYS);

  // reciprocals, rounded up, exact over the value ranges they see
  localparam int unsigned RED_SH = 45;
  localparam logic [30:0] RED_RECIP_C =
    31'(((64'd1 << RED_SH) + 64'(ROUND_DAYS) - 64'd1) / 64'(ROUND_DAYS));
  localparam int unsigned MID_SH = 24;
  localparam logic [15:0] R260_C = 16'(((1 << MID_SH) + 259) / 260);
  localparam logic [15:0] R365_C = 16'(((1 << MID_SH) + 364) / 365);
  localparam int unsigned LOW_SH = 16;
  localparam logic [11:0] R20_C = 12'(((1 << LOW_SH) + 19) / 20);
  localparam logic [12:0] R13_C = 13'(((1 << LOW_SH) + 12) / 13);

  typedef enum logic [1:0] {
    BEARER_TOCHTLI,
    BEARER_ACATL,
    BEARER_TECPATL,
    BEARER_CALLI
  } bearer_e;

  localparam logic [4:0] SIGN_TOCHTLI = 5'd7;
  localparam logic [4:0] SIGN_ACATL   = 5'd12;
  localparam logic [4:0] SIGN_TECPATL = 5'd17;
  localparam logic [4:0] SIGN_CALLI   = 5'd2;

  // residue of (hi << 14) for the upper six bits of the correlation value
  typedef logic [63:0][14:0] hi_tab_t;

  function automatic hi_tab_t hi_residues();
    hi_tab_t tab;
    for (int i = 0; i < 64; i++) begin
      tab[i] = 15'((i * (1 << CHUNK_W)) % ROUND_DAYS);
    end
    return tab;
  endfunction

  localparam hi_tab_t CORR_HI_RES = hi_residues();

endpackage

// ----- hdl/aztec_calendar_date_convert_unit.sv -----
// ------------------------------------------------------------------------
// aztec_calendar_date_convert_unit
// Converts a fixed-point Julian date into the Aztec day count, solar year
// and calendar round positions, using the correlation constant written on
// the configuration port. One word is accepted every clock cycle unless the
// output side stalls, which holds the whole ten-stage pipeline. Its depth is
// set by the chain of residue reductions: chunk folding of the day number, a
// reciprocal multiply by the round length, then the year and day-count
// reductions of the offset, each of them one multiply per stage. A new
// correlation constant is registered in corr_q and its residue in corr_res_q
// before the offset stage sees it.
// ------------------------------------------------------------------------
`include "aztec_calendar_date_convert_unit_assert.svh"

module aztec_calendar_date_convert_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [39:0] julian_date_fixed_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  tonal_sign_o,
  output logic [3:0]  tonal_num_o,
  output logic [8:0]  tonal_pos_o,
  output logic [8:0]  solar_day_o,
  output logic [4:0]  month_o,
  output logic [4:0]  month_day_o,
  output logic [1:0]  bearer_idx_o,
  output logic [3:0]  year_num_o,
  output logic [5:0]  round_pos_o,
  output logic        new_fire_o,
  output logic [14:0] days_to_new_fire_o
);
  import acdc_pkg::*;

  localparam int unsigned DAY_W = (FRACTION_BITS == 0) ? 40 : 41 - FRACTION_BITS;
  localparam int unsigned EXT_W = 3 * CHUNK_W;
  localparam logic [40:0] HALF  = (41'd1 << FRACTION_BITS) >> 1;

  logic en;
  logic [8:0] vld_q;
  logic out_valid_q;

  // configuration
  logic [19:0] corr_q;
  logic [14:0] corr_res_q, corr_res_d;
  logic [15:0] corr_sum;

  // stage payloads
  logic [40:0] date_sum;
  logic [DAY_W-1:0] day_q, day_d;
  logic [EXT_W-1:0] day_ext;
  logic [13:0] c0_q;
  logic [28:0] m1_q, m1_d, m2_q, m2_d;
  logic [29:0] s_q, s_d, s4_q;
  logic [60:0] prod_q, prod_d;
  logic [14:0] q5;
  logic [29:0] rday_full;
  logic [14:0] rday_q, rday_d;
  logic [15:0] off_diff;
  logic [14:0] o_q, o_d;
  logic [14:0] v1, v2;
  logic [30:0] pa, pb;
  logic [6:0]  qa_q, qa_d;
  logic [5:0]  qb_q, qb_d;
  logic [14:0] v1_q, v2_q, o7_q;
  logic [14:0] di_full, yd_full;
  logic [8:0]  di0_q, di0_d, yd0_q, yd0_d;
  logic [14:0] o8_q;
  logic [20:0] pd20, pd13, py20, py13;
  logic [4:0]  qd20, qd13, qy13;
  logic [4:0]  qy20_q, qy20_d;
  logic [8:0]  ds_full, dn_full, yr20_full, yr13_full;
  logic [4:0]  ds_q, ds_d, yr20_q, yr20_d;
  logic [3:0]  dn_q, dn_d, yr13_q, yr13_d;
  logic [8:0]  di9_q, yd9_q;
  logic [14:0] o9_q;

  // output stage
  logic [5:0]  sign_diff;
  logic [4:0]  ny_sign;
  logic [4:0]  num_diff;
  logic [3:0]  ny_num;
  bearer_e     bearer;
  logic [4:0]  out_sign_q;
  logic [3:0]  out_num_q;
  logic [8:0]  out_idx_q, out_yday_q;
  logic [4:0]  out_month_q, out_month_d, out_mday_q, out_mday_d;
  bearer_e     out_bearer_q;
  logic [3:0]  out_ynum_q;
  logic [5:0]  out_round_q, out_round_d;
  logic        out_fire_q;
  logic [14:0] out_dtnf_q, out_dtnf_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // correlation residue, one compare and subtract since the sum is below twice the round
  always_comb begin
    corr_sum   = 16'(corr_q[13:0]) + 16'(CORR_HI_RES[corr_q[19:14]]);
    corr_res_d = (corr_sum >= 16'(ROUND_C)) ? 15'(corr_sum - 16'(ROUND_C)) : corr_sum[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q     <= CORR_RESET;
      corr_res_q <= CORR_RESET_RES;
    end else begin
      if (cfg_valid_i) begin
        corr_q <= cfg_data_i;
      end
      corr_res_q <= corr_res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[7:0], in_valid_i};
      out_valid_q <= vld_q[8];
    end
  end

  always_comb begin
    // day number: add one half, floor
    date_sum = {1'b0, julian_date_fixed_i} + HALF;
    day_d    = DAY_W'(date_sum >> FRACTION_BITS);

    // fold the day number into a sum congruent modulo the round
    day_ext = EXT_W'(day_q);
    m1_d    = 29'(day_ext[2*CHUNK_W-1:CHUNK_W]) * 29'(K1_C);
    m2_d    = 29'(day_ext[3*CHUNK_W-1:2*CHUNK_W]) * 29'(K2_C);
    s_d     = 30'(c0_q) + 30'(m1_q) + 30'(m2_q);

    prod_d = 61'(s_q) * 61'(RED_RECIP_C);

    q5        = prod_q[RED_SH+14:RED_SH];
    rday_full = s4_q - 30'(q5) * 30'(ROUND_C);
    rday_d    = rday_full[14:0];

    // offset residue, wrap into the round
    off_diff = {1'b0, rday_q} - {1'b0, corr_res_q};
    o_d      = off_diff[15] ? off_diff[14:0] + ROUND_C : off_diff[14:0];

    v1   = o_q + TZOLKIN_BIAS;
    v2   = o_q + YEAR_BIAS;
    pa   = 31'(v1) * 31'(R260_C);
    pb   = 31'(v2) * 31'(R365_C);
    qa_d = pa[30:MID_SH];
    qb_d = pb[29:MID_SH];

    di_full = v1_q - 15'(qa_q) * 15'(TZOLKIN_LEN);
    yd_full = v2_q - 15'(qb_q) * 15'(YEAR_LEN);
    di0_d   = di_full[8:0];
    yd0_d   = yd_full[8:0];

    pd20      = 21'(di0_q) * 21'(R20_C);
    pd13      = 21'(di0_q) * 21'(R13_C);
    py20      = 21'(yd0_q) * 21'(R20_C);
    py13      = 21'(yd0_q) * 21'(R13_C);
    qd20      = pd20[20:LOW_SH];
    qd13      = pd13[20:LOW_SH];
    qy20_d    = py20[20:LOW_SH];
    qy13      = py13[20:LOW_SH];
    ds_full   = di0_q - 9'(qd20) * MONTH_LEN;
    dn_full   = di0_q - 9'(qd13) * TRECENA_LEN;
    yr20_full = yd0_q - 9'(qy20_d) * MONTH_LEN;
    yr13_full = yd0_q - 9'(qy13) * TRECENA_LEN;
    ds_d      = ds_full[4:0];
    dn_d      = dn_full[3:0];
    yr20_d    = yr20_full[4:0];
    yr13_d    = yr13_full[3:0];
  end

  // new year's day sits yd0 days back, so its sign and number follow by subtraction
  always_comb begin
    sign_diff = {1'b0, ds_q} - {1'b0, yr20_q};
    ny_sign   = sign_diff[5] ? sign_diff[4:0] + 5'(MONTH_LEN) : sign_diff[4:0];
    num_diff  = {1'b0, dn_q} - {1'b0, yr13_q};
    ny_num    = num_diff[4] ? num_diff[3:0] + 4'(TRECENA_LEN) : num_diff[3:0];

    case (ny_sign)
      SIGN_TOCHTLI: bearer = BEARER_TOCHTLI;
      SIGN_ACATL:   bearer = BEARER_ACATL;
      SIGN_TECPATL: bearer = BEARER_TECPATL;
      SIGN_CALLI:   bearer = BEARER_CALLI;
      default:      bearer = BEARER_TOCHTLI;
    endcase

    out_round_d = 6'(bearer) * 6'(TRECENA_LEN) + 6'(ny_num) + 6'd1;

    if (yd9_q < REG_DAYS) begin
      out_month_d = qy20_q + 5'd1;
      out_mday_d  = yr20_q + 5'd1;
    end else begin
      // nemontemi
      out_month_d = '0;
      out_mday_d  = 5'(yd9_q - (REG_DAYS - 9'd1));
    end

    if (o9_q == FIRE_OFS) begin
      out_dtnf_d = '0;
    end else if (o9_q > FIRE_OFS) begin
      out_dtnf_d = ROUND_C + FIRE_OFS - o9_q;
    end else begin
      out_dtnf_d = FIRE_OFS - o9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      day_q  <= day_d;
      c0_q   <= day_ext[CHUNK_W-1:0];
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      s_q    <= s_d;
      s4_q   <= s_q;
      prod_q <= prod_d;
      rday_q <= rday_d;
      o_q    <= o_d;
      qa_q   <= qa_d;
      qb_q   <= qb_d;
      v1_q   <= v1;
      v2_q   <= v2;
      o7_q   <= o_q;
      di0_q  <= di0_d;
      yd0_q  <= yd0_d;
      o8_q   <= o7_q;
      ds_q   <= ds_d;
      dn_q   <= dn_d;
      yr20_q <= yr20_d;
      yr13_q <= yr13_d;
      qy20_q <= qy20_d;
      di9_q  <= di0_q;
      yd9_q  <= yd0_q;
      o9_q   <= o8_q;

      out_sign_q   <= ds_q;
      out_num_q    <= dn_q + 4'd1;
      out_idx_q    <= di9_q + 9'd1;
      out_yday_q   <= yd9_q + 9'd1;
      out_month_q  <= out_month_d;
      out_mday_q   <= out_mday_d;
      out_bearer_q <= bearer;
      out_ynum_q   <= ny_num + 4'd1;
      out_round_q  <= out_round_d;
      out_fire_q   <= (o9_q == FIRE_OFS);
      out_dtnf_q   <= out_dtnf_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tonal_sign_o       = out_sign_q;
  assign tonal_num_o        = out_num_q;
  assign tonal_pos_o        = out_idx_q;
  assign solar_day_o        = out_yday_q;
  assign month_o            = out_month_q;
  assign month_day_o        = out_mday_q;
  assign bearer_idx_o       = out_bearer_q;
  assign year_num_o         = out_ynum_q;
  assign round_pos_o        = out_round_q;
  assign new_fire_o         = out_fire_q;
  assign days_to_new_fire_o = out_dtnf_q;

  `ACDC_ASSERT(a_corr_res_range, corr_res_q < ROUND_C, "correlation residue out of range")
  `ACDC_ASSERT(a_rday_range, vld_q[4] |-> rday_q < ROUND_C, "day residue not fully reduced")
  `ACDC_ASSERT(a_stall_freeze, out_valid_q && !out_ready_i |=> $stable(vld_q),
               "pipeline moved during stall")
  `ACDC_ASSERT(a_fire_day,
               out_valid_q && out_fire_q |->
                 out_yday_q == 9'd1 && out_month_q == 5'd1 && out_dtnf_q == '0,
               "new fire not on first day of year")
  `ACDC_ASSERT(a_nemontemi,
               out_valid_q && out_month_q == '0 |->
                 out_yday_q > REG_DAYS && out_mday_q <= 5'd5,
               "nemontemi month outside last five days")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aztec calendar date converter. Dates are
// pushed through the input channel while the output side stalls at random in some phases.
// Every accepted date is converted by a local calendar model under the
// correlation constant in force. The result words are compared in order.
// The constant is rewritten between phases, extremes included.
// ------------------------------------------------------------------------
module tb_top;
  import acdc_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam longint      HALF_UNIT    = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 0;
  localparam int          PIPE_LATENCY = 10;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          PHASE_DATES  = 250;

  typedef struct packed {
    logic [4:0]  tonal_sign;
    logic [3:0]  tonal_num;
    logic [8:0]  tonal_pos;
    logic [8:0]  solar_day;
    logic [4:0]  month;
    logic [4:0]  month_day;
    bearer_e     bearer_idx;
    logic [3:0]  year_num;
    logic [5:0]  round_pos;
    logic        new_fire;
    logic [14:0] days_to_new_fire;
  } calendar_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [39:0] julian_date_fixed_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  tonal_sign_o;
  logic [3:0]  tonal_num_o;
  logic [8:0]  tonal_pos_o;
  logic [8:0]  solar_day_o;
  logic [4:0]  month_o;
  logic [4:0]  month_day_o;
  logic [1:0]  bearer_idx_o;
  logic [3:0]  year_num_o;
  logic [5:0]  round_pos_o;
  logic        new_fire_o;
  logic [14:0] days_to_new_fire_o;

  calendar_t   expected_dates[$];
  logic [19:0] corr_seen = CORR_RESET;   // constant as the converter sees it
  logic [19:0] corr_set  = CORR_RESET;   // constant the stimulus works from
  int          fail_count = 0;
  int          n_dates;
  int          n_results = 0;
  int          n_corr_writes;
  int          idle_cycles = 0;
  bit          gap_mode;
  bit          stall_mode;

  aztec_calendar_date_convert_unit #(
    .FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .julian_date_fixed_i(julian_date_fixed_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .tonal_sign_o       (tonal_sign_o),
    .tonal_num_o        (tonal_num_o),
    .tonal_pos_o        (tonal_pos_o),
    .solar_day_o        (solar_day_o),
    .month_o            (month_o),
    .month_day_o        (month_day_o),
    .bearer_idx_o       (bearer_idx_o),
    .year_num_o         (year_num_o),
    .round_pos_o        (round_pos_o),
    .new_fire_o         (new_fire_o),
    .days_to_new_fire_o (days_to_new_fire_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint mod_pos(longint a, longint m);
    longint r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // full calendar position of one fixed-point date
  function automatic calendar_t calendar_of(logic [39:0] jd, logic [19:0] corr);
    calendar_t c;
    longint    day, off, yd0, yd, ny, pos;
    longint    ny_sign, ny_num;
    day = (longint'({24'd0, jd}) + HALF_UNIT) >> FRAC_BITS;
    off = day - longint'({44'd0, corr});
    yd0 = mod_pos(off + 347, 365);
    yd  = yd0 + 1;
    ny  = off - yd0;
    ny_sign = mod_pos(ny + 19, 20);
    ny_num  = mod_pos(ny + 3, 13) + 1;
    pos = mod_pos(off - 18, ROUND_DAYS);
    c.tonal_sign = 5'(mod_pos(off + 19, 20));
    c.tonal_num  = 4'(mod_pos(off + 3, 13) + 1);
    c.tonal_pos  = 9'(mod_pos(off + 159, 260) + 1);
    c.solar_day  = 9'(yd);
    if (yd <= 360) begin
      c.month     = 5'((yd - 1) / 20 + 1);
      c.month_day = 5'((yd - 1) % 20 + 1);
    end else begin
      c.month     = 5'd0;
      c.month_day = 5'(yd - 360);
    end
    case (5'(ny_sign))
      SIGN_ACATL:   c.bearer_idx = BEARER_ACATL;
      SIGN_TECPATL: c.bearer_idx = BEARER_TECPATL;
      SIGN_CALLI:   c.bearer_idx = BEARER_CALLI;
      default:      c.bearer_idx = BEARER_TOCHTLI;
    endcase
    c.year_num  = 4'(ny_num);
    c.round_pos = 6'(longint'(c.bearer_idx) * 13 + ny_num);
    c.new_fire  = (yd0 == 0) && (mod_pos(ny - 18, ROUND_DAYS) == 0);
    c.days_to_new_fire = (pos == 0) ? 15'd0 : 15'(ROUND_DAYS - pos);
    return c;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // predictor and scoreboard, all sampled on the rising edge
  always @(posedge clk_i) begin : result_check
    calendar_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) corr_seen = cfg_data_i;
      if (in_valid_i && in_ready_o)
        expected_dates.push_back(calendar_of(julian_date_fixed_i, corr_seen));
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_dates.size() == 0) begin
          $error("result word with no date pending");
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("tonal_sign", want.tonal_sign, tonal_sign_o);
          check_field("tonal_num", want.tonal_num, tonal_num_o);
          check_field("tonal_pos", want.tonal_pos, tonal_pos_o);
          check_field("solar_day", want.solar_day, solar_day_o);
          check_field("month", want.month, month_o);
          check_field("month_day", want.month_day, month_day_o);
          check_field("bearer_idx", want.bearer_idx, bearer_idx_o);
          check_field("year_num", want.year_num, year_num_o);
          check_field("round_pos", want.round_pos, round_pos_o);
          check_field("new_fire", want.new_fire, new_fire_o);
          check_field("days_to_new_fire", want.days_to_new_fire, days_to_new_fire_o);
        end
      end
    end
  end

  // no progress on any channel for too long ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("aztec_calendar_date_convert_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short, now and then long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // output backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (stall_mode && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        stall_left = pause_len() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [39:0] date_at(longint day, logic [15:0] frac);
    return (40'(day) << FRAC_BITS) | 40'(frac);
  endfunction

  // valid stays high into the next word unless a gap is taken
  task automatic send_date(input logic [39:0] jd);
    int gap;
    gap = 0;
    if (gap_mode && $urandom_range(0, 99) < 30) gap = pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    julian_date_fixed_i <= jd;
    do @(posedge clk_i); while (!in_ready_o);
    n_dates++;
  endtask

  // advance the clock first so the last accepted word is already queued
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_correlation(input logic [19:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    corr_set = value;
    n_corr_writes++;
  endtask

  // reset constant: input extremes, rounding at the half day, year and round edges
  task automatic test_epoch_landmarks();
    longint offs[14] = '{-1, 0, 12, 13, 14, 15, 16, 17, 18, 19, 383, 748, 1113, 18997};
    send_date(40'd0);
    send_date('1);
    send_date(date_at(corr_set + 17, 16'h7fff));
    send_date(date_at(corr_set + 17, 16'h8000));
    foreach (offs[i]) send_date(date_at(corr_set + offs[i], 16'h0000));
  endtask

  task automatic test_correlation_extremes();
    write_correlation(20'h00000);
    send_date(40'd0);
    send_date(date_at(18, 16'h0000));
    send_date(date_at(18 + ROUND_DAYS, 16'h1234));
    write_correlation(20'hfffff);
    send_date(40'd0);
    send_date('1);
    send_date(date_at(longint'(20'hfffff) + 18, 16'h0000));
    send_date(date_at(longint'(20'hfffff) - 1, 16'hffff));
    write_correlation(20'd584000);
    send_date(date_at(corr_set + 18, 16'h0000));
    send_date(date_at(corr_set + 365, 16'h8000));
    write_correlation(20'd584400);
    send_date(date_at(corr_set + 18, 16'h0000));
    send_date(date_at(corr_set - 18980, 16'h4000));
  endtask

  task automatic test_random_dates();
    int     sent, kind, k;
    longint day;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_correlation(CORR_RESET);
        1: write_correlation(20'd584000);
        2: write_correlation(20'd584400);
        3: write_correlation(20'($urandom()));
        default: write_correlation(20'($urandom_range(584000, 584400)));
      endcase
      gap_mode   = (phase == 1) || (phase >= 3);
      stall_mode = (phase >= 2);
      sent = 0;
      while (sent < PHASE_DATES) begin
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          send_date(40'({$urandom(), $urandom()}));
          sent++;
        end else if (kind < 70) begin
          day = longint'(corr_set) + int'($urandom_range(0, 120000)) - 60000;
          if (day < 0) day = -day;
          send_date(date_at(day, 16'($urandom())));
          sent++;
        end else begin
          // run of days across a new year, often a new fire year
          k = int'($urandom_range(0, 120)) - 60;
          if ($urandom_range(0, 2) == 0) k = 52 * (int'($urandom_range(0, 4)) - 2);
          day = longint'(corr_set) + 18 + 365 * k - $urandom_range(0, 6);
          if (day < 0) day = -day;
          for (int d = 0; d < 8; d++) send_date(date_at(day + d, 16'($urandom())));
          sent += 8;
        end
      end
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    julian_date_fixed_i <= '0;
    cfg_valid_i         <= 1'b0;
    cfg_data_i          <= '0;
    n_dates = 0;
    n_corr_writes = 0;
    gap_mode = 1'b0;
    stall_mode = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_epoch_landmarks();
    gap_mode = 1'b1;
    stall_mode = 1'b1;
    test_correlation_extremes();
    test_random_dates();
    wait_drained();

    $display("converted %0d dates under %0d correlation writes, %0d result words checked",
             n_dates, n_corr_writes, n_results);
    if (fail_count == 0) begin
      $display("aztec_calendar_date_convert_unit: match");
    end else begin
      $display("aztec_calendar_date_convert_unit: mismatch");
    end
    $finish;
  end

endmodule
